/* rtl/apc_pkg.sv */
// apc_pkg: shared types and constants of the affinity propagation cluster block
// no dependencies; used by affinity_propagation_cluster

package apc_pkg;

    localparam int DEF_MAX_SAMPLES = 64;
    localparam int DEF_VALUE_BITS  = 32;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DAMPING        = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITERATIONS = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STABLE_WINDOW  = 2'd3;

    localparam logic [6:0]  RST_SAMPLE_COUNT   = 7'd64;
    localparam logic [7:0]  RST_DAMPING        = 8'd128;
    localparam logic [15:0] RST_MAX_ITERATIONS = 16'd200;
    localparam logic [7:0]  RST_STABLE_WINDOW  = 8'd20;

    localparam logic [7:0] DAMP_MIN = 8'd3;
    localparam logic [7:0] DAMP_MAX = 8'd253;

    typedef struct packed {
        logic signed [31:0] similarity;
        logic               last_element;
    } t_in;

    typedef struct packed {
        logic [5:0]  sample_index;
        logic [5:0]  cluster_number;
        logic        is_exemplar;
        logic        converged;
        logic [15:0] iterations_used;
        logic        no_exemplar;
        logic        last_result;
    } t_out;

endpackage

/* rtl/apc_ram.sv */
// apc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module apc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/affinity_propagation_cluster.sv */
// affinity_propagation_cluster: damped affinity propagation over a loaded similarity matrix
// depends on apc_pkg and apc_ram
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+----------------------------------
//  item in  | i_start, o_busy, i_item        | taken when i_start & !o_busy
//  result   | o_valid, o_result              | one-cycle strobe, no back-pressure
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data| written when i_cfg_we is high
//
// matrix elements load one per cycle while the block is idle; the item with last_element starts a run
// run: clear pass over all MAX_SAMPLES^2 entries of both stores, then per iteration
//   the row and column passes, each updated entry using two reads and the shared damping unit
// output: n results, each after a scan over the exemplars
// reset is synchronous active low and clears control state only

module affinity_propagation_cluster #(
    parameter int MAX_SAMPLES = apc_pkg::DEF_MAX_SAMPLES,
    parameter int VALUE_BITS  = apc_pkg::DEF_VALUE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  apc_pkg::t_in                       i_item,
    output logic                               o_valid,
    output apc_pkg::t_out                      o_result,
    input  logic                               i_cfg_we,
    input  logic [apc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [apc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int IW    = $clog2(MAX_SAMPLES);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int DEPTH = MAX_SAMPLES * MAX_SAMPLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int VB    = VALUE_BITS;
    localparam int SW    = (VB + 11 > 33) ? VB + 11 : 33;
    localparam int PW    = VB + 10;

    localparam logic signed [VB-1:0] VMAX_V = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN_V = {1'b1, {(VB-1){1'b0}}};

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLR  = 4'd1;
    localparam logic [3:0] ST_RP1  = 4'd2;   // row maxima of s + a
    localparam logic [3:0] ST_RP2  = 4'd3;   // responsibility update of the row
    localparam logic [3:0] ST_AP1  = 4'd4;   // column sum of clipped responsibilities
    localparam logic [3:0] ST_AP2  = 4'd5;   // availability update of the column
    localparam logic [3:0] ST_EX   = 4'd6;   // exemplar extraction
    localparam logic [3:0] ST_CHK  = 4'd7;   // convergence bookkeeping
    localparam logic [3:0] ST_OUT  = 4'd8;   // nearest exemplar scan of one sample
    localparam logic [3:0] ST_EMIT = 4'd9;

    function automatic logic signed [VB-1:0] sat_v(input logic signed [SW-1:0] x);
        logic signed [VB-1:0] res;
        if (x > SW'(VMAX_V)) begin
            res = VMAX_V;
        end else if (x < SW'(VMIN_V)) begin
            res = VMIN_V;
        end else begin
            res = VB'(x);
        end
        return res;
    endfunction

    // configuration registers
    logic [6:0]  r_cfg_n;
    logic [7:0]  r_cfg_d;
    logic [15:0] r_cfg_max;
    logic [7:0]  r_cfg_win;

    // run control
    logic [3:0]            r_state;
    logic [1:0]            r_ph;
    logic [CW-1:0]         r_n;
    logic [7:0]            r_d;
    logic [7:0]            r_win;
    logic [IW-1:0]         r_i;
    logic [IW-1:0]         r_j;
    logic [IW-1:0]         r_k;
    logic signed [VB-1:0]  r_m1;
    logic signed [VB-1:0]  r_m2;
    logic signed [SW-1:0]  r_sum;
    logic signed [PW-1:0]  r_p1;
    logic signed [PW-1:0]  r_p2;
    logic [MAX_SAMPLES-1:0] r_mask_old;
    logic [MAX_SAMPLES-1:0] r_mask_new;
    logic [7:0]            r_st;
    logic [15:0]           r_iter;
    logic                  r_conv;
    logic [AW-1:0]         r_caddr;
    logic [AW-1:0]         r_lpos;
    logic [CW-1:0]         r_ord;
    logic [IW-1:0]         r_cl;
    logic                  r_have;
    logic signed [VB-1:0]  r_best;
    apc_pkg::t_out         r_out;
    logic                  r_oval;

    // memory ports
    logic          s_we, rs_we, a_we;
    logic [AW-1:0] s_waddr, s_raddr, x_addr, rs_raddr, a_raddr;
    logic [VB-1:0] s_wdata, rs_wdata, a_wdata;
    logic [VB-1:0] s_rdata, rs_rdata, a_rdata;

    logic [AW-1:0] addr_row, addr_col, addr_diag;
    logic [CW-1:0] side_m1;
    logic          j_last, i_last;

    // datapath
    logic signed [VB-1:0] s_v, rs_v, a_v, sa_v, sel_m, nv_r, clip_v, nv_a, dnew, dold;
    logic signed [SW-1:0] nv_a_w;
    logic signed [PW-1:0] coef_new, coef_old;
    logic signed [PW:0]   damp_y;
    logic signed [VB-1:0] damp_q;
    logic                 is_ex_k;
    logic                 ex_same;
    logic [7:0]           st_inc;
    logic [15:0]          iter_inc;
    logic                 chk_conv;
    logic                 item_ok;

    assign item_ok = i_start && !o_busy;

    assign side_m1 = r_n - CW'(1);
    assign j_last  = (CW'(r_j) == side_m1);
    assign i_last  = (CW'(r_i) == side_m1);

    assign addr_row  = AW'(AW'(r_i) * AW'(r_n) + AW'(r_j));
    assign addr_col  = AW'(AW'(r_j) * AW'(r_n) + AW'(r_i));
    assign addr_diag = AW'(AW'(r_j) * AW'(r_n) + AW'(r_j));

    // working address of each store for the current state
    always_comb begin
        s_raddr = addr_row;
        x_addr  = addr_row;
        if (r_state == ST_AP1 || r_state == ST_AP2) begin
            x_addr = addr_col;
        end else if (r_state == ST_EX) begin
            x_addr = addr_diag;
        end
        rs_raddr = x_addr;
        a_raddr  = x_addr;
    end

    assign s_v  = $signed(s_rdata);
    assign rs_v = $signed(rs_rdata);
    assign a_v  = $signed(a_rdata);

    always_comb begin
        sa_v   = sat_v(SW'(s_v) + SW'(a_v));
        sel_m  = (r_j == r_k) ? r_m2 : r_m1;
        nv_r   = sat_v(SW'(s_v) - SW'(sel_m));
        clip_v = (rs_v < 0 && r_j != r_i) ? '0 : rs_v;
        nv_a_w = r_sum - SW'(clip_v);
        if (nv_a_w > 0 && r_j != r_i) begin
            nv_a_w = '0;
        end
        nv_a   = sat_v(nv_a_w);
        dnew   = (r_state == ST_RP2) ? nv_r : nv_a;
        dold   = (r_state == ST_RP2) ? rs_v : a_v;
        is_ex_k = (SW'(rs_v) + SW'(a_v)) > 0;
    end

    // shared damping unit: products in phase 1, round and saturate in phase 2
    assign coef_new = PW'($signed({2'b00, 9'(9'd256 - {1'b0, r_d})}));
    assign coef_old = PW'($signed({3'b000, r_d}));
    assign damp_y   = (PW+1)'(r_p1) + (PW+1)'(r_p2) + (PW+1)'(128);
    assign damp_q   = sat_v(SW'(damp_y >>> 8));

    assign ex_same  = (r_mask_new != '0) && (r_mask_new == r_mask_old);
    assign st_inc   = r_st + 8'd1;
    assign iter_inc = r_iter + 16'd1;
    assign chk_conv = ex_same && (st_inc == r_win);

    // store writes
    always_comb begin
        logic signed [VB-1:0] in_sat;
        in_sat   = sat_v(SW'(i_item.similarity));
        s_we     = item_ok;
        s_waddr  = r_lpos;
        s_wdata  = in_sat;
        rs_we    = (r_state == ST_CLR) || (r_state == ST_RP2 && r_ph == 2'd2);
        a_we     = (r_state == ST_CLR) || (r_state == ST_AP2 && r_ph == 2'd2);
        rs_wdata = (r_state == ST_CLR) ? '0 : damp_q;
        a_wdata  = (r_state == ST_CLR) ? '0 : damp_q;
    end

    apc_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_sim_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    apc_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_resp_ram (
        .i_clk  (i_clk),
        .i_we   (rs_we),
        .i_waddr((r_state == ST_CLR) ? r_caddr : x_addr),
        .i_wdata(rs_wdata),
        .i_raddr(rs_raddr),
        .o_rdata(rs_rdata)
    );

    apc_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_avail_ram (
        .i_clk  (i_clk),
        .i_we   (a_we),
        .i_waddr((r_state == ST_CLR) ? r_caddr : x_addr),
        .i_wdata(a_wdata),
        .i_raddr(a_raddr),
        .o_rdata(a_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n   <= apc_pkg::RST_SAMPLE_COUNT;
            r_cfg_d   <= apc_pkg::RST_DAMPING;
            r_cfg_max <= apc_pkg::RST_MAX_ITERATIONS;
            r_cfg_win <= apc_pkg::RST_STABLE_WINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                apc_pkg::REG_SAMPLE_COUNT:   r_cfg_n   <= i_cfg_data[6:0];
                apc_pkg::REG_DAMPING:        r_cfg_d   <= i_cfg_data[7:0];
                apc_pkg::REG_MAX_ITERATIONS: r_cfg_max <= i_cfg_data;
                apc_pkg::REG_STABLE_WINDOW:  r_cfg_win <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ph       <= '0;
            r_lpos     <= '0;
            r_oval     <= 1'b0;
            r_mask_old <= '0;
            r_st       <= '0;
            r_iter     <= '0;
            r_conv     <= 1'b0;
        end else begin
            r_oval <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (item_ok) begin
                        if (i_item.last_element) begin
                            // latch the clamped run settings
                            if (r_cfg_n < 7'd2) begin
                                r_n <= CW'(2);
                            end else if (32'(r_cfg_n) > MAX_SAMPLES) begin
                                r_n <= CW'(MAX_SAMPLES);
                            end else begin
                                r_n <= CW'(r_cfg_n);
                            end
                            if (r_cfg_d < apc_pkg::DAMP_MIN) begin
                                r_d <= apc_pkg::DAMP_MIN;
                            end else if (r_cfg_d > apc_pkg::DAMP_MAX) begin
                                r_d <= apc_pkg::DAMP_MAX;
                            end else begin
                                r_d <= r_cfg_d;
                            end
                            r_win      <= (r_cfg_win == 8'd0) ? 8'd1 : r_cfg_win;
                            r_lpos     <= '0;
                            r_caddr    <= '0;
                            r_mask_old <= '0;
                            r_st       <= '0;
                            r_iter     <= '0;
                            r_conv     <= 1'b0;
                            r_state    <= ST_CLR;
                        end else begin
                            r_lpos <= r_lpos + AW'(1);
                        end
                    end
                end
                ST_CLR: begin
                    r_caddr <= r_caddr + AW'(1);
                    if (32'(r_caddr) == DEPTH - 1) begin
                        r_i  <= '0;
                        r_j  <= '0;
                        r_ph <= '0;
                        if (r_cfg_max == 16'd0) begin
                            r_ord   <= '0;
                            r_have  <= 1'b0;
                            r_cl    <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_m1    <= VMIN_V;
                            r_m2    <= VMIN_V;
                            r_k     <= '0;
                            r_state <= ST_RP1;
                        end
                    end
                end
                ST_RP1: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (sa_v > r_m1) begin
                            r_m2 <= r_m1;
                            r_m1 <= sa_v;
                            r_k  <= r_j;
                        end else if (sa_v > r_m2) begin
                            r_m2 <= sa_v;
                        end
                        if (j_last) begin
                            r_j     <= '0;
                            r_state <= ST_RP2;
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                    end
                end
                ST_RP2, ST_AP2: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else if (r_ph == 2'd1) begin
                        r_p1 <= PW'(dnew) * coef_new;
                        r_p2 <= PW'(dold) * coef_old;
                        r_ph <= 2'd2;
                    end else begin
                        r_ph <= 2'd0;
                        if (!j_last) begin
                            r_j <= r_j + IW'(1);
                        end else begin
                            r_j <= '0;
                            if (!i_last) begin
                                r_i <= r_i + IW'(1);
                                if (r_state == ST_RP2) begin
                                    r_m1    <= VMIN_V;
                                    r_m2    <= VMIN_V;
                                    r_k     <= '0;
                                    r_state <= ST_RP1;
                                end else begin
                                    r_sum   <= '0;
                                    r_state <= ST_AP1;
                                end
                            end else begin
                                r_i <= '0;
                                if (r_state == ST_RP2) begin
                                    r_sum   <= '0;
                                    r_state <= ST_AP1;
                                end else begin
                                    r_mask_new <= '0;
                                    r_state    <= ST_EX;
                                end
                            end
                        end
                    end
                end
                ST_AP1: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph  <= 2'd0;
                        r_sum <= r_sum + SW'(clip_v);
                        if (j_last) begin
                            r_j     <= '0;
                            r_state <= ST_AP2;
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                    end
                end
                ST_EX: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        r_mask_new[r_j] <= is_ex_k;
                        if (j_last) begin
                            r_j     <= '0;
                            r_state <= ST_CHK;
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                    end
                end
                ST_CHK: begin
                    if (ex_same) begin
                        r_st <= st_inc;
                    end else begin
                        r_mask_old <= r_mask_new;
                        r_st       <= '0;
                    end
                    r_conv <= chk_conv;
                    r_iter <= iter_inc;
                    r_i    <= '0;
                    r_j    <= '0;
                    if (chk_conv || iter_inc >= r_cfg_max) begin
                        r_ord   <= '0;
                        r_have  <= 1'b0;
                        r_cl    <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_m1    <= VMIN_V;
                        r_m2    <= VMIN_V;
                        r_k     <= '0;
                        r_state <= ST_RP1;
                    end
                end
                ST_OUT: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (r_mask_old[r_j]) begin
                            if (r_j == r_i) begin
                                r_cl <= IW'(r_ord);
                            end else if (!r_mask_old[r_i] && (!r_have || s_v > r_best)) begin
                                // first exemplar seeds the search, ties keep the earlier
                                r_best <= s_v;
                                r_cl   <= IW'(r_ord);
                                r_have <= 1'b1;
                            end
                            r_ord <= r_ord + CW'(1);
                        end
                        if (j_last) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                    end
                end
                ST_EMIT: begin
                    r_oval                <= 1'b1;
                    r_out.sample_index    <= 6'(r_i);
                    r_out.cluster_number  <= 6'(r_cl);
                    r_out.is_exemplar     <= r_mask_old[r_i];
                    r_out.converged       <= r_conv;
                    r_out.iterations_used <= r_conv ? r_iter : 16'd0;
                    r_out.no_exemplar     <= (r_mask_old == '0);
                    r_out.last_result     <= i_last;
                    r_j    <= '0;
                    r_ord  <= '0;
                    r_have <= 1'b0;
                    r_cl   <= '0;
                    if (i_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= ST_OUT;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_oval;
    assign o_result = r_out;

endmodule
